### hdl/speck_pkg.sv
// Shared types, constants and round functions for the Speck32/64 cipher core.
// No dependencies; imported by the core and its checker.
`timescale 1ns / 1ps

package speck_pkg;

  localparam int ROUND_COUNT = 22;
  localparam int WORD_W      = 16;
  localparam int KEY_WORDS   = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int ROT_ALPHA   = 7;
  localparam int ROT_BETA    = 2;
  localparam int IDX_W       = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam int ITEM_CYCLES = ROUND_COUNT + 1;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_KEY_WORD_0 = cfg_idx_t'(0);
  localparam cfg_idx_t REG_KEY_WORD_1 = cfg_idx_t'(1);
  localparam cfg_idx_t REG_KEY_WORD_2 = cfg_idx_t'(2);
  localparam cfg_idx_t REG_KEY_WORD_3 = cfg_idx_t'(3);

  localparam idx_t LAST_IDX = idx_t'(ROUND_COUNT - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOAD   = 4'b0010,
    ST_EXPAND = 4'b0100,
    ST_RUN    = 4'b1000
  } state_t;

  typedef struct packed {
    word_t x;
    word_t y;
  } pair_t;

  function automatic word_t rol(input word_t v, input int s);
    rol = (v << s) | (v >> (WORD_W - s));
  endfunction

  function automatic word_t ror(input word_t v, input int s);
    ror = (v >> s) | (v << (WORD_W - s));
  endfunction

  // forward round; also serves the key expansion with x = l word, y = key, k = index
  function automatic pair_t enc_round(input word_t x, input word_t y, input word_t k);
    pair_t r;
    r.x = (ror(x, ROT_ALPHA) + y) ^ k;
    r.y = rol(y, ROT_BETA) ^ r.x;
    enc_round = r;
  endfunction

  function automatic pair_t dec_round(input word_t x, input word_t y, input word_t k);
    pair_t r;
    r.y = ror(x ^ y, ROT_BETA);
    r.x = rol((x ^ k) - r.y, ROT_ALPHA);
    dec_round = r;
  endfunction

endpackage

### hdl/speck32_64_block_cipher_core.sv
// Speck32/64 cipher core: key registers, round key store, one shared round unit and a decryption round.
// Depends on speck_pkg.
`timescale 1ns / 1ps

// A block is accepted when start is high and busy is low. It then takes
// ROUND_COUNT rounds, one round per cycle, through the shared round unit to
// encrypt or the decryption round to decrypt. The result is registered with
// the last round and shown for exactly one cycle with out_valid. The receiver
// cannot stall, so capture the result in that cycle. A new block may be started
// in the same cycle the previous result is shown; no block is taken while one
// is in flight. After reset and after a key word write outside a block, the
// core reloads the key words, then expands the key schedule through the round
// unit. Busy is high during the write itself and throughout loading and
// expansion. A key write during loading or expansion restarts it. Write keys
// only while no block is in flight.
module speck32_64_block_cipher_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_action,
  input  speck_pkg::word_t    in_word_x,
  input  speck_pkg::word_t    in_word_y,
  output logic                out_valid,
  output speck_pkg::word_t    out_result_x,
  output speck_pkg::word_t    out_result_y,
  input  logic                cfg_we,
  input  speck_pkg::cfg_idx_t cfg_index,
  input  speck_pkg::word_t    cfg_data
);
  import speck_pkg::*;

  state_t state_r, state_nxt;
  idx_t   cnt_r, cnt_nxt;
  logic   act_r, act_nxt;
  logic   out_valid_r, out_valid_nxt;
  word_t  x_r, x_nxt, y_r, y_nxt;
  word_t  kcur_r, kcur_nxt;
  word_t  l0_r, l1_r, l2_r, l0_nxt, l1_nxt, l2_nxt;
  word_t  key_r [KEY_WORDS];
  word_t  rk_r [ROUND_COUNT];
  logic   rk_we;
  idx_t   rk_addr;
  word_t  rk_wdata;
  idx_t   kidx;
  word_t  rk;
  word_t  ux, uy, uk;
  pair_t  enc_out, dec_out;
  logic   cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == REG_KEY_WORD_0 || cfg_index == REG_KEY_WORD_1 ||
                              cfg_index == REG_KEY_WORD_2 || cfg_index == REG_KEY_WORD_3);

  assign kidx = act_r ? idx_t'(LAST_IDX - cnt_r) : cnt_r;
  assign rk   = rk_r[kidx];

  // shared round unit
  always_comb begin
    if (state_r == ST_EXPAND) begin
      ux = l0_r;
      uy = kcur_r;
      uk = word_t'(cnt_r);
    end else begin
      ux = x_r;
      uy = y_r;
      uk = rk;
    end
  end

  assign enc_out = enc_round(ux, uy, uk);
  assign dec_out = dec_round(x_r, y_r, rk);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    act_nxt       = act_r;
    out_valid_nxt = 1'b0;
    x_nxt         = x_r;
    y_nxt         = y_r;
    kcur_nxt      = kcur_r;
    l0_nxt        = l0_r;
    l1_nxt        = l1_r;
    l2_nxt        = l2_r;
    rk_we         = 1'b0;
    rk_addr       = cnt_r;
    rk_wdata      = enc_out.y;
    case (state_r)
      ST_IDLE: begin
        if (cfg_hit) begin
          state_nxt = ST_LOAD;
        end else if (start && !cfg_we) begin
          x_nxt     = in_word_x;
          y_nxt     = in_word_y;
          act_nxt   = in_action;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_LOAD: begin
        rk_we     = 1'b1;
        rk_addr   = '0;
        rk_wdata  = key_r[3];
        kcur_nxt  = key_r[3];
        l0_nxt    = key_r[2];
        l1_nxt    = key_r[1];
        l2_nxt    = key_r[0];
        cnt_nxt   = '0;
        state_nxt = cfg_hit ? ST_LOAD : ST_EXPAND;
      end
      ST_EXPAND: begin
        if (cfg_hit) begin
          state_nxt = ST_LOAD;
        end else if (cnt_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end else begin
          rk_we    = 1'b1;
          rk_addr  = idx_t'(cnt_r + 1'b1);
          rk_wdata = enc_out.y;
          kcur_nxt = enc_out.y;
          l0_nxt   = l1_r;
          l1_nxt   = l2_r;
          l2_nxt   = enc_out.x;
          cnt_nxt  = idx_t'(cnt_r + 1'b1);
        end
      end
      ST_RUN: begin
        x_nxt   = act_r ? dec_out.x : enc_out.x;
        y_nxt   = act_r ? dec_out.y : enc_out.y;
        cnt_nxt = idx_t'(cnt_r + 1'b1);
        if (cnt_r == LAST_IDX) begin
          cnt_nxt       = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_hit) begin
        key_r[cfg_index[1:0]] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    kcur_r <= kcur_nxt;
    l0_r   <= l0_nxt;
    l1_r   <= l1_nxt;
    l2_r   <= l2_nxt;
    if (rk_we) begin
      rk_r[rk_addr] <= rk_wdata;
    end
  end

  assign busy         = (state_r != ST_IDLE) || cfg_we;
  assign out_valid    = out_valid_r;
  assign out_result_x = x_r;
  assign out_result_y = y_r;

endmodule

### hdl/speck_checker.sv
// Port-level checks of the Speck32/64 core's sequencing, bound to the core.
// Depends on speck_pkg and speck32_64_block_cipher_core.
`timescale 1ns / 1ps

module speck_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_we
);
  import speck_pkg::*;

  logic accept;
  assign accept = start && !busy;

  a_reset_expands: assert property (@(posedge clk) !rst_n |=> busy && !out_valid)
    else $error("core not busy expanding keys after reset");

  a_item_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(ITEM_CYCLES) out_valid)
    else $error("result not delivered at the expected cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy && !out_valid)
    else $error("core not busy while an item is in flight");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy || cfg_we))
    else $error("core busy while showing a result");

endmodule

bind speck32_64_block_cipher_core speck_checker u_speck_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_we    (cfg_we)
);
